// File: hdl/spq_pkg.sv
// spq_pkg: types, status codes and defaults for the sorted priority queue
// no dependencies; used by spq_cell, sorted_priority_queue_top and spq_chk
package spq_pkg;

  localparam int unsigned DepthDefault = 16;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef struct packed {
    logic [7:0]  prio;
    logic [15:0] data;
  } entry_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  priority_req;
    logic [15:0] payload;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_priority;
    logic [15:0] out_payload;
  } rsp_t;

  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

// File: hdl/spq_cell.sv
// spq_cell: one slot of the sorted shift-register queue
// depends on spq_pkg; instantiated in a row by sorted_priority_queue_top
module spq_cell (
  input  logic                clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic                occupied,
  input  logic                left_place,
  input  spq_pkg::entry_t     left_entry,
  input  spq_pkg::entry_t     right_entry,
  output logic                place,
  output spq_pkg::entry_t     entry
);

  // new item belongs at or before this slot
  assign place = !occupied || (entry.prio > ctrl.new_entry.prio);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (place && !left_place) begin
        entry <= ctrl.new_entry;
      end else if (place) begin
        entry <= left_entry;
      end
    end else if (ctrl.rem) begin
      entry <= right_entry;
    end
  end

endmodule

// File: hdl/sorted_priority_queue_top.sv
// sorted_priority_queue_top: bounded priority queue as a row of shifting cells
// depends on spq_pkg and spq_cell
//
//   channel  valid      stall      payload  item
//   request  req_valid  req_stall  req      insert or remove
//   result   rsp_valid  rsp_stall  rsp      status and removed entry
//
// one item per cycle while req_stall is low: every cell compares against the
// new priority in parallel and shifts one place, so an insert or a remove is one shift
// the result register shows the outcome in the cycle after the item is taken
// req_stall follows a stalled, still-full result register
// rst clears the entry count and the result valid; cell contents need none
module sorted_priority_queue_top #(
  parameter int unsigned DEPTH = spq_pkg::DepthDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  spq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output spq_pkg::rsp_t rsp
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]       count;
  logic                take;
  logic                full;
  logic                empty;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::rsp_t       rsp_next;
  logic                place   [DEPTH];
  spq_pkg::entry_t     entries [DEPTH];

  assign req_stall = rsp_valid && rsp_stall;
  assign take      = req_valid && !req_stall;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);

  assign ctrl.ins            = take && (req.func == spq_pkg::FUNC_INSERT) && !full;
  assign ctrl.rem            = take && (req.func == spq_pkg::FUNC_REMOVE) && !empty;
  assign ctrl.new_entry.prio = req.priority_req;
  assign ctrl.new_entry.data = req.payload;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      spq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occupied    (count > CW'(i)),
        .left_place  ((i == 0) ? 1'b0 : place[(i == 0) ? 0 : i - 1]),
        .left_entry  (entries[(i == 0) ? 0 : i - 1]),
        .right_entry (entries[(i == DEPTH - 1) ? i : i + 1]),
        .place       (place[i]),
        .entry       (entries[i])
      );
    end
  endgenerate

  always_comb begin
    rsp_next = '0;
    if (req.func == spq_pkg::FUNC_INSERT) begin
      rsp_next.status = full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
    end else if (empty) begin
      rsp_next.status = spq_pkg::ST_EMPTY;
    end else begin
      rsp_next.status       = spq_pkg::ST_OK;
      rsp_next.out_priority = entries[0].prio;
      rsp_next.out_payload  = entries[0].data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (ctrl.ins) begin
        count <= count + CW'(1);
      end else if (ctrl.rem) begin
        count <= count - CW'(1);
      end
      if (take) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp <= rsp_next;
    end
  end

endmodule

// File: hdl/spq_chk.sv
// spq_chk: port-level checks for sorted_priority_queue_top
// depends on spq_pkg; attached to the top level by the bind below
module spq_chk (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input spq_pkg::rsp_t rsp
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // every accepted item yields a result next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> rsp_valid)
    else $error("accepted item gave no result");

  // request side only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid)
    else $error("request stalled with no result pending");

  // failed operations carry no entry
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == spq_pkg::ST_FULL || rsp.status == spq_pkg::ST_EMPTY)
    |-> rsp.out_priority == 8'd0 && rsp.out_payload == 16'd0)
    else $error("failed operation returned an entry");

  // insert of a full queue cannot be followed directly by an empty remove
  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_stall && rsp.status == spq_pkg::ST_FULL
    ##1 rsp_valid && $past(req_valid && !req_stall)
    |-> rsp.status != spq_pkg::ST_EMPTY)
    else $error("queue went from full to empty in one item");

endmodule

bind sorted_priority_queue_top spq_chk u_spq_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
